@@ rtl/hbs_pkg.sv @@
// Shared constants, register codes and the box-mean arithmetic for the height map smoother.
`default_nettype none

package hbs_pkg;

    localparam int LINE_DEPTH = 1024;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 8;
    localparam int HGT_W      = 12;
    localparam int SUM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [10:0] MIN_WIDTH  = 11'd3;
    localparam logic [10:0] MAX_WIDTH  = 11'd1024;
    localparam logic [11:0] MIN_HEIGHT = 12'd3;

    localparam logic [COL_W-1:0] RESET_LAST_COL = 10'd255;
    localparam logic [ROW_W-1:0] RESET_LAST_ROW = 12'd255;

    // x / 9 == (x * 58255) >> 19 exactly for x < 74898
    localparam logic [15:0] RECIP_NINE = 16'd58255;
    localparam int          RECIP_SH   = 19;

    // Slot order inside one transaction's result bundle (raster order)
    localparam int SLOT_LEFT  = 0;
    localparam int SLOT_MEAN  = 1;
    localparam int SLOT_RIGHT = 2;
    localparam int SLOT_RAW   = 3;
    localparam int NUM_SLOTS  = 4;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // round(sum * 16 / 9)
    function automatic logic [HGT_W-1:0] box_mean(input logic [SUM_W-1:0] sum);
        logic [15:0] scaled;
        logic [31:0] prod;
        scaled = {sum, 4'b0000} + 16'd4;
        prod   = scaled * RECIP_NINE;
        return prod[RECIP_SH+HGT_W-1:RECIP_SH];
    endfunction

endpackage

`default_nettype wire

@@ rtl/hbs_line_store.sv @@
// Two line stores packed side by side in one memory: upper row in the high byte.
`default_nettype none

module hbs_line_store (
    input  wire logic                         aclk,
    input  wire logic                         rd_en,
    input  wire logic [hbs_pkg::COL_W-1:0]    rd_addr,
    output logic      [2*hbs_pkg::PIX_W-1:0]  rd_data_reg,
    input  wire logic                         wr_en,
    input  wire logic [hbs_pkg::COL_W-1:0]    wr_addr,
    input  wire logic [2*hbs_pkg::PIX_W-1:0]  wr_data
);

    logic [2*hbs_pkg::PIX_W-1:0] mem [hbs_pkg::LINE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/heightmap_box3x3_smoother_top.sv @@
// Top level of the streaming 3x3 box smoother for height maps.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  input    | s_valid / s_ready   | s_sample[7:0]
//  result   | m_valid / m_ready   | m_height_out, m_out_col, m_out_row,
//           |                     | m_is_smoothed, m_last_of_run
//  config   | cfg_we              | cfg_index[1:0], cfg_wdata[11:0]
//
// A sample accepted into the input register moves on to the result bundle register, from
// which its first result is presented.
// The result port sends one result per clock while m_ready is high; samples with at most
// one result sustain one per clock, samples with two or three results (row ends from row 2
// on, and the last row apart from its second column) hold the next sample until their last is taken.
// Reset (aresetn low, synchronous) sets width and height to 256 and restarts the
// frame; the line stores need no clearing. Any write to a known register also
// restarts the frame. m_ready low holds the result bundle and, once the input
// register fills, drops s_ready.
`default_nettype none

module heightmap_box3x3_smoother_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [hbs_pkg::PIX_W-1:0]         s_sample,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [hbs_pkg::HGT_W-1:0]         m_height_out,
    output logic      [hbs_pkg::COL_W-1:0]         m_out_col,
    output logic      [hbs_pkg::ROW_W-1:0]         m_out_row,
    output logic                                   m_is_smoothed,
    output logic                                   m_last_of_run,
    input  wire logic                              cfg_we,
    input  wire logic [hbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hbs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int PW = hbs_pkg::PIX_W;
    localparam int CW = hbs_pkg::COL_W;
    localparam int RW = hbs_pkg::ROW_W;

    // configuration, kept as last column / last row index
    logic [CW-1:0] last_col_reg;
    logic [RW-1:0] last_row_reg;
    logic          restart;

    // raster position of the next transaction
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // input register stage
    logic          s1_valid_reg;
    logic [PW-1:0] s1_sample_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic [2*PW-1:0] line_rd_reg;
    logic [PW-1:0] s1_up, s1_mid;
    logic          s1_go;
    logic          s_accept;

    // two columns of the window behind the current one
    logic [PW-1:0] win_reg [6];

    // result bundle
    hbs_pkg::slot_mask_t s2_mask_reg, s2_mask_next, s1_mask, s2_low;
    logic [hbs_pkg::HGT_W-1:0] s2_mean_reg;
    logic [PW-1:0]             s2_mid_reg, s2_cur_reg;
    logic [CW-1:0]             s2_col_reg;
    logic [RW-1:0]             s2_row_reg;
    logic                      s2_last;
    logic [hbs_pkg::SUM_W-1:0] box_sum;

    assign restart = cfg_we && (cfg_index == hbs_pkg::REG_FRAME_WIDTH ||
                                cfg_index == hbs_pkg::REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= hbs_pkg::RESET_LAST_COL;
            last_row_reg <= hbs_pkg::RESET_LAST_ROW;
        end else if (cfg_we) begin
            case (cfg_index)
                hbs_pkg::REG_FRAME_WIDTH: begin
                    if (cfg_wdata[10:0] < hbs_pkg::MIN_WIDTH)
                        last_col_reg <= CW'(hbs_pkg::MIN_WIDTH - 11'd1);
                    else if (cfg_wdata[10:0] > hbs_pkg::MAX_WIDTH)
                        last_col_reg <= CW'(hbs_pkg::MAX_WIDTH - 11'd1);
                    else
                        last_col_reg <= CW'(cfg_wdata[10:0] - 11'd1);
                end
                hbs_pkg::REG_FRAME_HEIGHT: begin
                    if (cfg_wdata < hbs_pkg::MIN_HEIGHT)
                        last_row_reg <= hbs_pkg::MIN_HEIGHT - 12'd1;
                    else
                        last_row_reg <= cfg_wdata - 12'd1;
                end
                default: begin
                end
            endcase
        end
    end

    assign s_accept = s_valid && s_ready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (col_reg == last_col_reg) begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // read both lines at acceptance, write the middle line and the new sample back when the transaction leaves
    hbs_line_store u_line_store (
        .aclk        (aclk),
        .rd_en       (s_accept),
        .rd_addr     (col_reg),
        .rd_data_reg (line_rd_reg),
        .wr_en       (s1_go),
        .wr_addr     (s1_col_reg),
        .wr_data     ({s1_mid, s1_sample_reg})
    );

    assign s1_up  = line_rd_reg[2*PW-1:PW];
    assign s1_mid = line_rd_reg[PW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_sample_reg <= s_sample;
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end else if (s1_go) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= s1_up;
            win_reg[1] <= s1_mid;
            win_reg[2] <= s1_sample_reg;
        end
    end

    always_comb begin
        box_sum = hbs_pkg::SUM_W'(s1_up) + hbs_pkg::SUM_W'(s1_mid)
                + hbs_pkg::SUM_W'(s1_sample_reg);
        for (int i = 0; i < 6; i++) box_sum = box_sum + hbs_pkg::SUM_W'(win_reg[i]);
    end

    // which results this transaction causes
    always_comb begin
        s1_mask = '0;
        s1_mask[hbs_pkg::SLOT_LEFT]  = (s1_row_reg >= RW'(2)) && (s1_col_reg == '0);
        s1_mask[hbs_pkg::SLOT_MEAN]  = (s1_row_reg >= RW'(2)) && (s1_col_reg >= CW'(2));
        s1_mask[hbs_pkg::SLOT_RIGHT] = (s1_row_reg >= RW'(2)) && (s1_col_reg == last_col_reg);
        s1_mask[hbs_pkg::SLOT_RAW]   = (s1_row_reg == '0) || (s1_row_reg == last_row_reg);
    end

    assign s2_low  = s2_mask_reg & ~(s2_mask_reg - 1'b1);
    assign s2_last = (s2_mask_reg & (s2_mask_reg - 1'b1)) == '0;
    assign m_valid = s2_mask_reg != '0;

    // advance when the bundle is empty or its final result goes out now
    assign s1_go   = s1_valid_reg && (!m_valid || (m_ready && s2_last));
    assign s_ready = !s1_valid_reg || s1_go;

    always_comb begin
        s2_mask_next = s2_mask_reg;
        if (s1_go)
            s2_mask_next = s1_mask;
        else if (m_valid && m_ready)
            s2_mask_next = s2_mask_reg & (s2_mask_reg - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_mask_reg <= '0;
        end else begin
            s2_mask_reg <= s2_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            s2_mean_reg <= hbs_pkg::box_mean(box_sum);
            s2_mid_reg  <= s1_mid;
            s2_cur_reg  <= s1_sample_reg;
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
        end
    end

    always_comb begin
        m_height_out  = {s2_cur_reg, 4'b0000};
        m_out_col     = s2_col_reg;
        m_out_row     = s2_row_reg;
        m_is_smoothed = 1'b0;
        if (s2_low[hbs_pkg::SLOT_LEFT]) begin
            m_height_out = {s2_mid_reg, 4'b0000};
            m_out_col    = '0;
            m_out_row    = s2_row_reg - 1'b1;
        end else if (s2_low[hbs_pkg::SLOT_MEAN]) begin
            m_height_out  = s2_mean_reg;
            m_out_col     = s2_col_reg - 1'b1;
            m_out_row     = s2_row_reg - 1'b1;
            m_is_smoothed = 1'b1;
        end else if (s2_low[hbs_pkg::SLOT_RIGHT]) begin
            m_height_out = {s2_mid_reg, 4'b0000};
            m_out_row    = s2_row_reg - 1'b1;
        end
    end

    assign m_last_of_run = s2_last;

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_bundle_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid)
        else $error("result bundle ended without a last flag");

    a_mean_is_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_smoothed |-> m_out_col != '0 && m_out_row != '0 &&
                                     m_out_col != last_col_reg)
        else $error("box mean emitted for a border pixel");

    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= last_col_reg && row_reg <= last_row_reg)
        else $error("raster position outside the frame");

endmodule

`default_nettype wire
